[rtl/core/array_bst_insert_traverse_top_defines.svh]
// Assertion macros shared by the RTL of the array BST block.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef ARRAY_BST_INSERT_TRAVERSE_TOP_DEFINES_SVH
`define ARRAY_BST_INSERT_TRAVERSE_TOP_DEFINES_SVH

// same-cycle implication
`define ABST_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/abst_pkg.sv]
// Shared constants, types and helpers for the array BST block.
// No dependencies.
package abst_pkg;

  localparam int unsigned Levels   = 6;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned PortKeyW = 16;
  localparam int unsigned Slots    = (1 << Levels) - 1;
  localparam int unsigned SlotW    = Levels;
  localparam int unsigned CurW     = Levels + 1;

  typedef logic [KeyW-1:0]     key_t;
  typedef logic [PortKeyW-1:0] port_key_t;
  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [CurW-1:0]     cur_t;

  typedef enum logic [1:0] {
    OrdIn    = 2'd0,
    OrdPre   = 2'd1,
    OrdPost  = 2'd2,
    OrdLevel = 2'd3
  } order_e;

  localparam logic CmdInsert    = 1'b0;
  localparam logic CmdTraverse  = 1'b1;
  localparam logic KindStatus   = 1'b0;
  localparam logic KindKey      = 1'b1;
  localparam logic StatusStored = 1'b0;
  localparam logic StatusNoRoom = 1'b1;

  // zero-extend or truncate between the internal key and the port key
  function automatic port_key_t to_port_key(key_t k);
    logic [KeyW+PortKeyW-1:0] ext;
    ext = {{PortKeyW{1'b0}}, k};
    return ext[PortKeyW-1:0];
  endfunction

  function automatic key_t from_port_key(port_key_t p);
    logic [KeyW+PortKeyW-1:0] ext;
    ext = {{KeyW{1'b0}}, p};
    return ext[KeyW-1:0];
  endfunction

endpackage

[rtl/core/abst_if.sv]
// Valid/ready channel interfaces for command and result transactions.
// Depends on abst_pkg.
interface abst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [abst_pkg::PortKeyW-1:0] key;
  logic [1:0]                  order;

  modport source (output valid, command, key, order, input ready);
  modport sink   (input valid, command, key, order, output ready);
endinterface

interface abst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic                        status;
  logic [abst_pkg::PortKeyW-1:0] out_key;
  logic                        key_valid;
  logic                        last;

  modport source (output valid, kind, status, out_key, key_valid, last, input ready);
  modport sink   (input valid, kind, status, out_key, key_valid, last, output ready);
endinterface

[rtl/core/abst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module abst_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 63,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/array_bst_insert_traverse_top.sv]
// Array BST top: insert and in/pre/post/level-order traverse over 63 slots.
// Insert: steps StInsRd then StInsCmp per occupied level, then stores the key in a free
// slot or reports no room. Traverse: depth-first orders read the key RAM for each key;
// level order scans all 63 slots and reads each occupied one. One command at a time.
// Reset (async, active low) clears occupancy and control; stored keys are not cleared.
// Uses abst_pkg, abst_if, abst_ram and the assertion macro header.
`include "array_bst_insert_traverse_top_defines.svh"

module array_bst_insert_traverse_top (
  input logic       clk_i,
  input logic       rst_ni,
  abst_in_if.sink   in_i,
  abst_out_if.source out_o
);
  import abst_pkg::*;

  // sequencer states
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StInsRd   = 3'd1;  // check slot, write or launch key read
  localparam logic [2:0] StInsCmp  = 3'd2;  // compare stored key, step to child
  localparam logic [2:0] StDfStep  = 3'd3;  // depth-first walk: decide move / emit
  localparam logic [2:0] StDfKey   = 3'd4;  // depth-first walk: key read done, push it
  localparam logic [2:0] StLvlScan = 3'd5;  // level order: scan occupancy
  localparam logic [2:0] StLvlKey  = 3'd6;  // level order: key read done, push it
  localparam logic [2:0] StFin     = 3'd7;  // flush held key with last set

  // how the depth-first walk arrived at the current slot
  localparam logic [1:0] PhDown  = 2'd0;
  localparam logic [1:0] PhFromL = 2'd1;
  localparam logic [1:0] PhFromR = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  cur_t             cur_q, cur_d;     // slot under the walk, also the level-order index
  logic [Slots-1:0] used_q, used_d;   // occupancy, one flop per slot
  key_t             key_q, key_d;
  order_e           order_q, order_d;

  // one-entry hold so the final key of a traverse can carry last
  logic             pend_valid_q, pend_valid_d;
  key_t             pend_key_q, pend_key_d;

  // result register, parts the engine from the output handshake
  logic             out_valid_q, out_valid_d;
  logic             out_kind_q, out_kind_d;
  logic             out_status_q, out_status_d;
  key_t             out_key_q, out_key_d;
  logic             out_kval_q, out_kval_d;
  logic             out_last_q, out_last_d;

  logic             ram_we;
  key_t             ram_rdata;
  slot_t            cur_slot;
  logic             cur_in;
  logic             cur_node;
  logic             out_free;
  logic             can_push;
  logic             do_push;

  // depth-first move for the current slot and phase
  logic             emit_here;
  cur_t             mv_cur;
  logic [1:0]       mv_phase;
  logic             mv_done;
  cur_t             cur_up;
  logic [1:0]       phase_up;
  cur_t             child_l;
  cur_t             child_r;

  assign cur_slot = cur_q[SlotW-1:0];
  assign cur_in   = (cur_q < cur_t'(Slots));
  assign cur_node = cur_in && used_q[cur_slot];
  assign out_free = !out_valid_q || out_o.ready;
  assign can_push = !pend_valid_q || out_free;

  assign child_l  = {cur_q[CurW-2:0], 1'b1};
  assign child_r  = {cur_q[CurW-2:0] + (CurW-1)'(1), 1'b0};
  assign cur_up   = cur_t'((cur_q - cur_t'(1)) >> 1);
  assign phase_up = cur_q[0] ? PhFromL : PhFromR;  // odd slots are left children

  always_comb begin
    emit_here = 1'b0;
    mv_cur    = cur_q;
    mv_phase  = phase_q;
    mv_done   = 1'b0;
    unique case (phase_q)
      PhDown: begin
        if (cur_node) begin
          emit_here = (order_q == OrdPre);
          mv_cur    = child_l;
          mv_phase  = PhDown;
        end else if (cur_q == '0) begin
          mv_done = 1'b1;
        end else begin
          mv_cur   = cur_up;
          mv_phase = phase_up;
        end
      end
      PhFromL: begin
        emit_here = (order_q == OrdIn);
        mv_cur    = child_r;
        mv_phase  = PhDown;
      end
      PhFromR: begin
        emit_here = (order_q == OrdPost);
        if (cur_q == '0) begin
          mv_done = 1'b1;
        end else begin
          mv_cur   = cur_up;
          mv_phase = phase_up;
        end
      end
      default: begin
        mv_done = 1'b1;
      end
    endcase
  end

  // key store; the read address always follows the current slot, so read data
  // stays put while the engine stalls on a full result register
  abst_ram #(
    .Width (KeyW),
    .Depth (Slots)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_slot),
    .wdata_i (key_q),
    .raddr_i (cur_slot),
    .rdata_o (ram_rdata)
  );

  assign ram_we  = (state_q == StInsRd) && cur_in && !used_q[cur_slot] && out_free;
  assign do_push = ((state_q == StDfKey) || (state_q == StLvlKey)) && can_push;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    used_d       = used_q;
    key_d        = key_q;
    order_d      = order_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_kval_d   = out_kval_q;
    out_last_d   = out_last_q;

    if (ram_we) begin
      used_d[cur_slot] = 1'b1;
    end

    // a pushed key goes to the hold; the key it displaces leaves as a result
    if (do_push) begin
      pend_valid_d = 1'b1;
      pend_key_d   = ram_rdata;
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_kind_d   = KindKey;
        out_status_d = StatusStored;
        out_key_d    = pend_key_q;
        out_kval_d   = 1'b1;
        out_last_d   = 1'b0;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          key_d   = from_port_key(in_i.key);
          order_d = order_e'(in_i.order);
          cur_d   = '0;
          phase_d = PhDown;
          if (in_i.command == CmdInsert) begin
            state_d = StInsRd;
          end else if (!used_q[0]) begin
            state_d = StFin;  // empty tree: one result without a key
          end else if (order_e'(in_i.order) == OrdLevel) begin
            state_d = StLvlScan;
          end else begin
            state_d = StDfStep;
          end
        end
      end
      StInsRd: begin
        if (!cur_in || !used_q[cur_slot]) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KindStatus;
            out_status_d = cur_in ? StatusStored : StatusNoRoom;
            out_key_d    = '0;
            out_kval_d   = 1'b0;
            out_last_d   = 1'b1;
            state_d      = StIdle;
          end
        end else begin
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        // equal keys go left
        cur_d   = (ram_rdata < key_q) ? child_r : child_l;
        state_d = StInsRd;
      end
      StDfStep: begin
        if (emit_here) begin
          state_d = StDfKey;
        end else if (mv_done) begin
          state_d = StFin;
        end else begin
          cur_d   = mv_cur;
          phase_d = mv_phase;
        end
      end
      StDfKey: begin
        if (can_push) begin
          if (mv_done) begin
            state_d = StFin;
          end else begin
            cur_d   = mv_cur;
            phase_d = mv_phase;
            state_d = StDfStep;
          end
        end
      end
      StLvlScan: begin
        if (!cur_in) begin
          state_d = StFin;
        end else if (used_q[cur_slot]) begin
          state_d = StLvlKey;
        end else begin
          cur_d = cur_q + cur_t'(1);
        end
      end
      StLvlKey: begin
        if (can_push) begin
          cur_d   = cur_q + cur_t'(1);
          state_d = StLvlScan;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KindKey;
          out_status_d = StatusStored;
          out_key_d    = pend_valid_q ? pend_key_q : '0;
          out_kval_d   = pend_valid_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      phase_q      <= PhDown;
      cur_q        <= '0;
      used_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      cur_q        <= cur_d;
      used_q       <= used_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    order_q      <= order_d;
    pend_key_q   <= pend_key_d;
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_kval_q   <= out_kval_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready      = (state_q == StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_key   = to_port_key(out_key_q);
  assign out_o.key_valid = out_kval_q;
  assign out_o.last      = out_last_q;

  `ABST_ASSERT(a_write_free_slot, ram_we, !used_q[cur_slot], "insert wrote an occupied slot")
  `ABST_ASSERT_NEXT(a_used_sticky, 1'b1, &(used_q | ~$past(used_q)), "occupancy cleared")
  `ABST_ASSERT(a_fin_has_key, (state_q == StFin) && used_q[0], pend_valid_q, "no key at end")
  `ABST_ASSERT(a_status_last, out_valid_q && (out_kind_q == KindStatus), out_last_q, "no last flag")

endmodule
